// File: src/stok_pkg.sv
// Package for the source tokenizer: token kinds, lexer modes, character codes,
// the result record and the keyword / operator lookup functions.
// No dependencies.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int KW_MAX_CHARS = 8;
    localparam int MAX_RES = 5;
    localparam int RES_IDX_W = 3;

    // lexer modes
    localparam logic [3:0] M_START   = 4'd0;
    localparam logic [3:0] M_HOLD    = 4'd1;
    localparam logic [3:0] M_IDENT   = 4'd2;
    localparam logic [3:0] M_NUM     = 4'd3;
    localparam logic [3:0] M_NUMDOT  = 4'd4;
    localparam logic [3:0] M_FRAC    = 4'd5;
    localparam logic [3:0] M_STR     = 4'd6;
    localparam logic [3:0] M_ESC     = 4'd7;
    localparam logic [3:0] M_COMMENT = 4'd8;

    // token kinds
    localparam logic [5:0] K_ILLEGAL = 6'd0;
    localparam logic [5:0] K_EOF     = 6'd1;
    localparam logic [5:0] K_EOL     = 6'd2;
    localparam logic [5:0] K_IDENT   = 6'd3;
    localparam logic [5:0] K_INT     = 6'd4;
    localparam logic [5:0] K_FLOAT   = 6'd5;
    localparam logic [5:0] K_STR     = 6'd6;
    localparam logic [5:0] K_TYPE    = 6'd7;
    localparam logic [5:0] K_ASSIGN  = 6'd8;
    localparam logic [5:0] K_EQ      = 6'd9;
    localparam logic [5:0] K_NE      = 6'd10;
    localparam logic [5:0] K_NOT     = 6'd11;
    localparam logic [5:0] K_LT      = 6'd12;
    localparam logic [5:0] K_LE      = 6'd13;
    localparam logic [5:0] K_GT      = 6'd14;
    localparam logic [5:0] K_GE      = 6'd15;
    localparam logic [5:0] K_AND     = 6'd16;
    localparam logic [5:0] K_OR      = 6'd17;
    localparam logic [5:0] K_PLUS    = 6'd18;
    localparam logic [5:0] K_MINUS   = 6'd19;
    localparam logic [5:0] K_STAR    = 6'd20;
    localparam logic [5:0] K_SLASH   = 6'd21;
    localparam logic [5:0] K_PCT     = 6'd22;
    localparam logic [5:0] K_LPAREN  = 6'd23;
    localparam logic [5:0] K_RPAREN  = 6'd24;
    localparam logic [5:0] K_LBRACE  = 6'd25;
    localparam logic [5:0] K_RBRACE  = 6'd26;
    localparam logic [5:0] K_LBRACK  = 6'd27;
    localparam logic [5:0] K_RBRACK  = 6'd28;
    localparam logic [5:0] K_COMMA   = 6'd29;
    localparam logic [5:0] K_COLON   = 6'd30;
    localparam logic [5:0] K_FN      = 6'd31;
    localparam logic [5:0] K_LET     = 6'd32;
    localparam logic [5:0] K_RETURN  = 6'd33;
    localparam logic [5:0] K_IF      = 6'd34;
    localparam logic [5:0] K_ELIF    = 6'd35;
    localparam logic [5:0] K_ELSE    = 6'd36;
    localparam logic [5:0] K_WHILE   = 6'd37;
    localparam logic [5:0] K_CONT    = 6'd38;
    localparam logic [5:0] K_BREAK   = 6'd39;
    localparam logic [5:0] K_COPY    = 6'd40;
    localparam logic [5:0] K_TRUE    = 6'd41;
    localparam logic [5:0] K_FALSE   = 6'd42;
    localparam logic [5:0] K_LAST    = K_FALSE;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  lit;
        logic        bvalid;
        logic        tend;
        logic [15:0] line;
    } tok_res_t;

    function automatic tok_res_t mk_res(input logic [5:0] kind, input logic [7:0] lit,
                                        input logic bvalid, input logic tend,
                                        input logic [15:0] line);
        tok_res_t r;
        r.kind   = kind;
        r.lit    = bvalid ? lit : 8'h00;
        r.bvalid = bvalid;
        r.tend   = tend;
        r.line   = line;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        logic [5:0] k;
        unique case (b)
            8'h3D:   k = K_ASSIGN;
            8'h21:   k = K_NOT;
            8'h3C:   k = K_LT;
            8'h3E:   k = K_GT;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h25:   k = K_PCT;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h2C:   k = K_COMMA;
            8'h3A:   k = K_COLON;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    // Right-aligned string literal -> first char in byte 0, zero padded.
    function automatic logic [8*KW_MAX_CHARS-1:0] pack_word(input logic [63:0] s,
                                                          input int len);
        logic [8*KW_MAX_CHARS-1:0] w;
        w = '0;
        for (int i = 0; i < KW_MAX_CHARS; i++)
        begin
            if (i < len)
            begin
                w[8*i +: 8] = s[8*(len-1-i) +: 8];
            end
        end
        return w;
    endfunction

    // Buffer bytes past the identifier length are zero, so a padded compare
    // also checks the length.
    function automatic logic [5:0] word_kind(input logic [8*KW_MAX_CHARS-1:0] w);
        logic [5:0] k;
        k = K_IDENT;
        if (w == pack_word(64'("fn"), 2))          k = K_FN;
        else if (w == pack_word(64'("let"), 3))    k = K_LET;
        else if (w == pack_word(64'("return"), 6)) k = K_RETURN;
        else if (w == pack_word(64'("if"), 2))     k = K_IF;
        else if (w == pack_word(64'("elif"), 4))   k = K_ELIF;
        else if (w == pack_word(64'("else"), 4))   k = K_ELSE;
        else if (w == pack_word(64'("while"), 5))  k = K_WHILE;
        else if (w == pack_word(64'("cont"), 4))   k = K_CONT;
        else if (w == pack_word(64'("break"), 5))  k = K_BREAK;
        else if (w == pack_word(64'("copy"), 4))   k = K_COPY;
        else if (w == pack_word(64'("true"), 4))   k = K_TRUE;
        else if (w == pack_word(64'("false"), 5))  k = K_FALSE;
        else if (w == pack_word(64'("bool"), 4))   k = K_TYPE;
        else if (w == pack_word(64'("array"), 5))  k = K_TYPE;
        else if (w == pack_word(64'("map"), 3))    k = K_TYPE;
        else if (w == pack_word(64'("str"), 3))    k = K_TYPE;
        else if (w == pack_word(64'("nil"), 3))    k = K_TYPE;
        else if (w == pack_word(64'("int"), 3))    k = K_TYPE;
        else if (w == pack_word(64'("float"), 5))  k = K_TYPE;
        else if (w == pack_word(64'("obj"), 3))    k = K_TYPE;
        return k;
    endfunction

endpackage

// File: src/stok_if.sv
// Valid/ready channel interfaces for the source tokenizer: byte input and
// token result output. Depends on nothing.
`timescale 1ns / 1ps

interface stok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

interface stok_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [7:0]  literal_byte;
    logic        byte_valid;
    logic        token_end;
    logic [15:0] line_number;
    logic        last_in_run;

    modport source (output valid, output token_kind, output literal_byte,
                    output byte_valid, output token_end, output line_number,
                    output last_in_run, input ready);
    modport sink (input valid, input token_kind, input literal_byte,
                  input byte_valid, input token_end, input line_number,
                  input last_in_run, output ready);
endinterface

// File: src/source_tokenizer_unit.sv
// Streaming maximal-munch tokenizer, top level.
// Depends on stok_pkg and the channel interfaces in stok_if.sv.
`timescale 1ns / 1ps

// Usage:
//   char_in   : one source byte per transaction; byte 0 ends input (EOF),
//               bytes after it are lexed as a continuation.
//   token_out : one result per transaction: a literal byte tagged with its
//               kind, or a byteless closing marker, plus line number,
//               token_end and last_in_run (last result of one input byte).
// Each accepted byte is lexed in the cycle it is accepted and produces 0 to 4
// results into a result buffer; results appear on token_out the next cycle.
// Throughput: one byte per cycle while each byte yields at most one result and
// token_out does not stall; a byte yielding N results holds the output until all N
// are delivered, and the next byte is taken in the cycle the last of them is delivered.
// Reset (rst_n low, async) empties the result buffer, returns the lexer to
// token start and sets the line counter to 1.
// If token_out stalls, the buffer holds, and char_in.ready drops once the
// pending results are not about to drain.
module source_tokenizer_unit #(
    parameter int LINE_BITS     = stok_pkg::LINE_BITS_DEF,
    parameter int KEYWORD_CHARS = stok_pkg::KEYWORD_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    stok_char_if.sink        char_in,
    stok_tok_if.source       token_out
);

    localparam int LEN_W = $clog2(KEYWORD_CHARS + 2);
    localparam int KW_W  = 8 * stok_pkg::KW_MAX_CHARS;
    localparam int IDX_W = stok_pkg::RES_IDX_W;

    logic [3:0]               mode_reg, mode_next;
    logic [7:0]               held_reg, held_next;
    logic [8*KEYWORD_CHARS-1:0] kw_reg, kw_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;

    stok_pkg::tok_res_t       res_reg [stok_pkg::MAX_RES];
    stok_pkg::tok_res_t       res_next [stok_pkg::MAX_RES];
    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         idx_reg;

    logic in_fire, out_fire;

    assign out_fire      = token_out.valid && token_out.ready;
    assign in_fire       = char_in.valid && char_in.ready;
    assign char_in.ready = (idx_reg == cnt_reg) ||
                           ((idx_reg + IDX_W'(1) == cnt_reg) && token_out.ready);

    always_comb
    begin
        logic [7:0]           b;
        logic [7:0]           h;
        logic [7:0]           want;
        logic [7:0]           c;
        logic [5:0]           pair_k;
        logic [5:0]           lone_k;
        logic                 do_disp;
        logic [LINE_BITS-1:0] line_cur;
        logic [IDX_W-1:0]     n;
        logic [KW_W-1:0]      kw_wide;

        b        = char_in.source_byte;
        h        = held_reg;
        want     = stok_pkg::CH_EQ;
        c        = b;
        pair_k   = stok_pkg::K_ILLEGAL;
        lone_k   = stok_pkg::K_ILLEGAL;
        do_disp  = 1'b0;
        line_cur = line_reg;
        n        = '0;
        kw_wide  = KW_W'(kw_reg);

        mode_next = mode_reg;
        held_next = held_reg;
        kw_next   = kw_reg;
        len_next  = len_reg;
        for (int i = 0; i < stok_pkg::MAX_RES; i++)
        begin
            res_next[i] = '0;
        end

        unique case (mode_reg)
            stok_pkg::M_HOLD:
            begin
                held_next = 8'h00;
                if (h == stok_pkg::CH_CR)
                begin
                    if (b == stok_pkg::CH_LF)
                    begin
                        res_next[0] = stok_pkg::mk_res(stok_pkg::K_EOL, stok_pkg::CH_BSL,
                                                       1'b1, 1'b0, 16'(line_cur));
                        res_next[1] = stok_pkg::mk_res(stok_pkg::K_EOL, stok_pkg::CH_LC_R,
                                                       1'b1, 1'b0, 16'(line_cur));
                        res_next[2] = stok_pkg::mk_res(stok_pkg::K_EOL, stok_pkg::CH_BSL,
                                                       1'b1, 1'b0, 16'(line_cur));
                        res_next[3] = stok_pkg::mk_res(stok_pkg::K_EOL, stok_pkg::CH_LC_N,
                                                       1'b1, 1'b1, 16'(line_cur));
                        n = IDX_W'(4);
                        if (line_cur != '1)
                        begin
                            line_cur = line_cur + LINE_BITS'(1);
                        end
                        mode_next = stok_pkg::M_START;
                    end
                    else
                    begin
                        res_next[0] = stok_pkg::mk_res(stok_pkg::K_ILLEGAL, h,
                                                       1'b1, 1'b1, 16'(line_cur));
                        n = IDX_W'(1);
                        if (line_cur != '1)
                        begin
                            line_cur = line_cur + LINE_BITS'(1);
                        end
                        do_disp = 1'b1;
                    end
                end
                else
                begin
                    priority case (h)
                        stok_pkg::CH_EQ:
                        begin
                            want = stok_pkg::CH_EQ;  pair_k = stok_pkg::K_EQ;
                            lone_k = stok_pkg::K_ASSIGN;
                        end
                        stok_pkg::CH_BANG:
                        begin
                            want = stok_pkg::CH_EQ;  pair_k = stok_pkg::K_NE;
                            lone_k = stok_pkg::K_NOT;
                        end
                        stok_pkg::CH_LT:
                        begin
                            want = stok_pkg::CH_EQ;  pair_k = stok_pkg::K_LE;
                            lone_k = stok_pkg::K_LT;
                        end
                        stok_pkg::CH_GT:
                        begin
                            want = stok_pkg::CH_EQ;  pair_k = stok_pkg::K_GE;
                            lone_k = stok_pkg::K_GT;
                        end
                        stok_pkg::CH_AMP:
                        begin
                            want = stok_pkg::CH_AMP; pair_k = stok_pkg::K_AND;
                            lone_k = stok_pkg::K_ILLEGAL;
                        end
                        default:
                        begin
                            want = stok_pkg::CH_BAR; pair_k = stok_pkg::K_OR;
                            lone_k = stok_pkg::K_ILLEGAL;
                        end
                    endcase
                    if (b == want)
                    begin
                        res_next[0] = stok_pkg::mk_res(pair_k, h, 1'b1, 1'b0, 16'(line_cur));
                        res_next[1] = stok_pkg::mk_res(pair_k, b, 1'b1, 1'b1, 16'(line_cur));
                        n = IDX_W'(2);
                        mode_next = stok_pkg::M_START;
                    end
                    else
                    begin
                        res_next[0] = stok_pkg::mk_res(lone_k, h, 1'b1, 1'b1, 16'(line_cur));
                        n = IDX_W'(1);
                        do_disp = 1'b1;
                    end
                end
            end
            stok_pkg::M_IDENT:
            begin
                if (stok_pkg::is_word(b))
                begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                    begin
                        if (len_reg == LEN_W'(i))
                        begin
                            kw_next[8*i +: 8] = b;
                        end
                    end
                    if (len_reg <= LEN_W'(KEYWORD_CHARS))
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_IDENT, b, 1'b1, 1'b0,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                end
                else
                begin
                    res_next[0] = stok_pkg::mk_res(
                        (len_reg > LEN_W'(KEYWORD_CHARS)) ? stok_pkg::K_IDENT
                                                          : stok_pkg::word_kind(kw_wide),
                        8'h00, 1'b0, 1'b1, 16'(line_cur));
                    n = IDX_W'(1);
                    do_disp = 1'b1;
                end
            end
            stok_pkg::M_NUM:
            begin
                if (stok_pkg::is_digit(b))
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_INT, b, 1'b1, 1'b0,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                end
                else if (b == stok_pkg::CH_DOT)
                begin
                    held_next = stok_pkg::CH_DOT;
                    mode_next = stok_pkg::M_NUMDOT;
                end
                else
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_INT, 8'h00, 1'b0, 1'b1,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                    do_disp = 1'b1;
                end
            end
            stok_pkg::M_NUMDOT:
            begin
                held_next = 8'h00;
                if (stok_pkg::is_digit(b))
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_FLOAT, stok_pkg::CH_DOT,
                                                   1'b1, 1'b0, 16'(line_cur));
                    res_next[1] = stok_pkg::mk_res(stok_pkg::K_FLOAT, b, 1'b1, 1'b0,
                                                   16'(line_cur));
                    n = IDX_W'(2);
                    mode_next = stok_pkg::M_FRAC;
                end
                else
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_INT, 8'h00, 1'b0, 1'b1,
                                                   16'(line_cur));
                    res_next[1] = stok_pkg::mk_res(stok_pkg::K_ILLEGAL, stok_pkg::CH_DOT,
                                                   1'b1, 1'b1, 16'(line_cur));
                    n = IDX_W'(2);
                    do_disp = 1'b1;
                end
            end
            stok_pkg::M_FRAC:
            begin
                if (stok_pkg::is_digit(b))
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_FLOAT, b, 1'b1, 1'b0,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                end
                else
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_FLOAT, 8'h00, 1'b0, 1'b1,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                    do_disp = 1'b1;
                end
            end
            stok_pkg::M_STR:
            begin
                if (b == stok_pkg::CH_QUOTE)
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_STR, 8'h00, 1'b0, 1'b1,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                    mode_next = stok_pkg::M_START;
                end
                else if ((b == stok_pkg::CH_NUL) || (b == stok_pkg::CH_LF))
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_STR, 8'h00, 1'b0, 1'b1,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                    do_disp = 1'b1;
                end
                else if (b == stok_pkg::CH_BSL)
                begin
                    mode_next = stok_pkg::M_ESC;
                end
                else
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_STR, b, 1'b1, 1'b0,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                end
            end
            stok_pkg::M_ESC:
            begin
                if (b == stok_pkg::CH_NUL)
                begin
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_STR, 8'h00, 1'b0, 1'b1,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                    do_disp = 1'b1;
                end
                else
                begin
                    if (b == stok_pkg::CH_LC_N)
                    begin
                        c = stok_pkg::CH_LF;
                    end
                    else if (b == stok_pkg::CH_LC_T)
                    begin
                        c = stok_pkg::CH_TAB;
                    end
                    res_next[0] = stok_pkg::mk_res(stok_pkg::K_STR, c, 1'b1, 1'b0,
                                                   16'(line_cur));
                    n = IDX_W'(1);
                    mode_next = stok_pkg::M_STR;
                end
            end
            stok_pkg::M_COMMENT:
            begin
                do_disp = (b == stok_pkg::CH_LF) || (b == stok_pkg::CH_NUL);
            end
            default:
            begin
                do_disp = 1'b1;
            end
        endcase

        // token start: at most one result, placed after those above
        if (do_disp)
        begin
            mode_next = stok_pkg::M_START;
            priority if (b == stok_pkg::CH_NUL)
            begin
                res_next[n] = stok_pkg::mk_res(stok_pkg::K_EOF, 8'h00, 1'b0, 1'b1,
                                               16'(line_cur));
                n = n + IDX_W'(1);
            end
            else if ((b == stok_pkg::CH_SPACE) || (b == stok_pkg::CH_TAB))
            begin
                mode_next = stok_pkg::M_START;
            end
            else if (b == stok_pkg::CH_LF)
            begin
                res_next[n] = stok_pkg::mk_res(stok_pkg::K_EOL, b, 1'b1, 1'b1,
                                               16'(line_cur));
                n = n + IDX_W'(1);
                if (line_cur != '1)
                begin
                    line_cur = line_cur + LINE_BITS'(1);
                end
            end
            else if ((b == stok_pkg::CH_CR) || (b == stok_pkg::CH_EQ) ||
                     (b == stok_pkg::CH_BANG) || (b == stok_pkg::CH_LT) ||
                     (b == stok_pkg::CH_GT) || (b == stok_pkg::CH_AMP) ||
                     (b == stok_pkg::CH_BAR))
            begin
                held_next = b;
                mode_next = stok_pkg::M_HOLD;
            end
            else if (b == stok_pkg::CH_QUOTE)
            begin
                mode_next = stok_pkg::M_STR;
            end
            else if (b == stok_pkg::CH_HASH)
            begin
                mode_next = stok_pkg::M_COMMENT;
            end
            else if (stok_pkg::is_alpha(b) || (b == stok_pkg::CH_UNDER))
            begin
                kw_next       = '0;
                kw_next[7:0]  = b;
                len_next      = LEN_W'(1);
                mode_next     = stok_pkg::M_IDENT;
                res_next[n]   = stok_pkg::mk_res(stok_pkg::K_IDENT, b, 1'b1, 1'b0,
                                                 16'(line_cur));
                n = n + IDX_W'(1);
            end
            else if (stok_pkg::is_digit(b))
            begin
                mode_next   = stok_pkg::M_NUM;
                res_next[n] = stok_pkg::mk_res(stok_pkg::K_INT, b, 1'b1, 1'b0,
                                               16'(line_cur));
                n = n + IDX_W'(1);
            end
            else
            begin
                res_next[n] = stok_pkg::mk_res(stok_pkg::single_kind(b), b, 1'b1, 1'b1,
                                               16'(line_cur));
                n = n + IDX_W'(1);
            end
        end

        line_next = line_cur;
        cnt_next  = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stok_pkg::M_START;
            held_reg <= '0;
            kw_reg   <= '0;
            len_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                kw_reg   <= kw_next;
                len_reg  <= len_next;
                line_reg <= line_next;
                cnt_reg  <= cnt_next;
                idx_reg  <= '0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign token_out.valid        = (idx_reg != cnt_reg);
    assign token_out.token_kind   = res_reg[idx_reg].kind;
    assign token_out.literal_byte = res_reg[idx_reg].lit;
    assign token_out.byte_valid   = res_reg[idx_reg].bvalid;
    assign token_out.token_end    = res_reg[idx_reg].tend;
    assign token_out.line_number  = res_reg[idx_reg].line;
    assign token_out.last_in_run  = (idx_reg + IDX_W'(1) == cnt_reg);

endmodule

// File: src/stok_checker.sv
// Port-level assertions for the source tokenizer and the bind that attaches
// them to source_tokenizer_unit. Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [7:0]  literal_byte,
    input logic        byte_valid,
    input logic        token_end,
    input logic [15:0] line_number,
    input logic        last_in_run
);

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
        $stable(literal_byte) && $stable(line_number) && $stable(last_in_run))
        else $error("stalled result changed");

    // byteless markers always close a token and carry a zero byte
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> token_end && (literal_byte == 8'h00))
        else $error("marker malformed");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= stok_pkg::K_LAST)
        else $error("token kind out of range");

    // a run of results never ends mid-token except for open literal tokens
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_in_run && !token_end |->
        (token_kind == stok_pkg::K_IDENT) || (token_kind == stok_pkg::K_INT) ||
        (token_kind == stok_pkg::K_FLOAT) || (token_kind == stok_pkg::K_STR))
        else $error("fixed token split across input bytes");

endmodule

bind source_tokenizer_unit stok_port_checker u_stok_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (token_out.valid),
    .out_ready    (token_out.ready),
    .token_kind   (token_out.token_kind),
    .literal_byte (token_out.literal_byte),
    .byte_valid   (token_out.byte_valid),
    .token_end    (token_out.token_end),
    .line_number  (token_out.line_number),
    .last_in_run  (token_out.last_in_run)
);

// File: tb/stok_checker.sv
// Token stream checker for the source tokenizer: predicts results from the
// accepted source bytes and compares every delivered token result.
// Depends on stok_pkg and the channel interfaces in stok_if.sv.
`timescale 1ns / 1ps

module stok_checker
    import stok_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    stok_char_if  char_mon,
    stok_tok_if   tok_mon,
    output int    fail_count,
    output int    pending_count
);

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  lit;
        logic        bvalid;
        logic        tend;
        logic [15:0] line;
        logic        last;
    } tok_exp_t;

    localparam logic [15:0] LINE_TOP = 16'hFFFF;

    tok_exp_t    exp_tokens[$];
    logic [3:0]  lex_mode;
    logic [7:0]  lookahead;
    logic [7:0]  kw_buf [KEYWORD_CHARS_DEF];
    int          word_len;
    logic [15:0] cur_line;
    tok_exp_t    burst[$];

    assign pending_count = exp_tokens.size();

    function automatic logic [5:0] fixed_kind(input logic [7:0] b);
        case (b)
            8'h3D: return K_ASSIGN;
            8'h21: return K_NOT;
            8'h3C: return K_LT;
            8'h3E: return K_GT;
            8'h2B: return K_PLUS;
            8'h2D: return K_MINUS;
            8'h2A: return K_STAR;
            8'h2F: return K_SLASH;
            8'h25: return K_PCT;
            8'h28: return K_LPAREN;
            8'h29: return K_RPAREN;
            8'h7B: return K_LBRACE;
            8'h7D: return K_RBRACE;
            8'h5B: return K_LBRACK;
            8'h5D: return K_RBRACK;
            8'h2C: return K_COMMA;
            8'h3A: return K_COLON;
            default: return K_ILLEGAL;
        endcase
    endfunction

    function automatic logic digit_ch(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic alpha_ch(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic word_ch(input logic [7:0] b);
        return alpha_ch(b) || digit_ch(b) || b == CH_UNDER;
    endfunction

    function automatic string word_text();
        string s;
        s = "";
        for (int i = 0; i < word_len && i < KEYWORD_CHARS_DEF; i++)
            s = {s, string'(kw_buf[i])};
        return s;
    endfunction

    function automatic logic [5:0] classify_word();
        string s;
        if (word_len > KEYWORD_CHARS_DEF)
            return K_IDENT;
        s = word_text();
        case (s)
            "fn": return K_FN;
            "let": return K_LET;
            "return": return K_RETURN;
            "if": return K_IF;
            "elif": return K_ELIF;
            "else": return K_ELSE;
            "while": return K_WHILE;
            "cont": return K_CONT;
            "break": return K_BREAK;
            "copy": return K_COPY;
            "true": return K_TRUE;
            "false": return K_FALSE;
            "bool", "array", "map", "str", "nil", "int", "float", "obj": return K_TYPE;
            default: return K_IDENT;
        endcase
    endfunction

    task automatic push_tok(input logic [5:0] k, input logic [7:0] b,
                            input logic v, input logic e);
        tok_exp_t t;
        t.kind = k;
        t.lit = v ? b : 8'h00;
        t.bvalid = v;
        t.tend = e;
        t.line = cur_line;
        t.last = 1'b0;
        if (burst.size() < MAX_RES)
            burst.push_back(t);
    endtask

    task automatic bump_line();
        if (cur_line != LINE_TOP)
            cur_line++;
    endtask

    task automatic start_token(input logic [7:0] b);
        lex_mode = M_START;
        case (b)
            CH_NUL: push_tok(K_EOF, 0, 0, 1);
            CH_SPACE, CH_TAB: ;
            CH_LF:
            begin
                push_tok(K_EOL, b, 1, 1);
                bump_line();
            end
            CH_CR, CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR:
            begin
                lookahead = b;
                lex_mode = M_HOLD;
            end
            CH_QUOTE: lex_mode = M_STR;
            CH_HASH: lex_mode = M_COMMENT;
            default:
            begin
                if (alpha_ch(b) || b == CH_UNDER)
                begin
                    word_len = 1;
                    kw_buf[0] = b;
                    lex_mode = M_IDENT;
                    push_tok(K_IDENT, b, 1, 0);
                end
                else if (digit_ch(b))
                begin
                    lex_mode = M_NUM;
                    push_tok(K_INT, b, 1, 0);
                end
                else
                begin
                    push_tok(fixed_kind(b), b, 1, 1);
                end
            end
        endcase
    endtask

    task automatic settle_lookahead(input logic [7:0] b);
        logic [7:0] h;
        logic [7:0] want;
        logic [5:0] pair_k;
        logic [5:0] lone_k;
        h = lookahead;
        lookahead = 0;
        if (h == CH_CR)
        begin
            if (b == CH_LF)
            begin
                push_tok(K_EOL, CH_BSL, 1, 0);
                push_tok(K_EOL, CH_LC_R, 1, 0);
                push_tok(K_EOL, CH_BSL, 1, 0);
                push_tok(K_EOL, CH_LC_N, 1, 1);
                bump_line();
                lex_mode = M_START;
            end
            else
            begin
                push_tok(K_ILLEGAL, h, 1, 1);
                bump_line();
                start_token(b);
            end
            return;
        end
        case (h)
            CH_EQ:   begin want = CH_EQ;  pair_k = K_EQ;  lone_k = K_ASSIGN;  end
            CH_BANG: begin want = CH_EQ;  pair_k = K_NE;  lone_k = K_NOT;     end
            CH_LT:   begin want = CH_EQ;  pair_k = K_LE;  lone_k = K_LT;      end
            CH_GT:   begin want = CH_EQ;  pair_k = K_GE;  lone_k = K_GT;      end
            CH_AMP:  begin want = CH_AMP; pair_k = K_AND; lone_k = K_ILLEGAL; end
            default: begin want = CH_BAR; pair_k = K_OR;  lone_k = K_ILLEGAL; end
        endcase
        if (b == want)
        begin
            push_tok(pair_k, h, 1, 0);
            push_tok(pair_k, b, 1, 1);
            lex_mode = M_START;
        end
        else
        begin
            push_tok(lone_k, h, 1, 1);
            start_token(b);
        end
    endtask

    task automatic lex_byte(input logic [7:0] b);
        burst.delete();
        case (lex_mode)
            M_HOLD: settle_lookahead(b);
            M_IDENT:
                if (word_ch(b))
                begin
                    if (word_len < KEYWORD_CHARS_DEF)
                        kw_buf[word_len] = b;
                    if (word_len <= KEYWORD_CHARS_DEF)
                        word_len++;
                    push_tok(K_IDENT, b, 1, 0);
                end
                else
                begin
                    push_tok(classify_word(), 0, 0, 1);
                    start_token(b);
                end
            M_NUM:
                if (digit_ch(b))
                    push_tok(K_INT, b, 1, 0);
                else if (b == CH_DOT)
                begin
                    lookahead = CH_DOT;
                    lex_mode = M_NUMDOT;
                end
                else
                begin
                    push_tok(K_INT, 0, 0, 1);
                    start_token(b);
                end
            M_NUMDOT:
            begin
                lookahead = 0;
                if (digit_ch(b))
                begin
                    push_tok(K_FLOAT, CH_DOT, 1, 0);
                    push_tok(K_FLOAT, b, 1, 0);
                    lex_mode = M_FRAC;
                end
                else
                begin
                    push_tok(K_INT, 0, 0, 1);
                    push_tok(K_ILLEGAL, CH_DOT, 1, 1);
                    start_token(b);
                end
            end
            M_FRAC:
                if (digit_ch(b))
                    push_tok(K_FLOAT, b, 1, 0);
                else
                begin
                    push_tok(K_FLOAT, 0, 0, 1);
                    start_token(b);
                end
            M_STR:
                if (b == CH_QUOTE)
                begin
                    push_tok(K_STR, 0, 0, 1);
                    lex_mode = M_START;
                end
                else if (b == CH_NUL || b == CH_LF)
                begin
                    push_tok(K_STR, 0, 0, 1);
                    start_token(b);
                end
                else if (b == CH_BSL)
                    lex_mode = M_ESC;
                else
                    push_tok(K_STR, b, 1, 0);
            M_ESC:
                if (b == CH_NUL)
                begin
                    push_tok(K_STR, 0, 0, 1);
                    start_token(b);
                end
                else
                begin
                    push_tok(K_STR, b == CH_LC_N ? CH_LF : b == CH_LC_T ? CH_TAB : b,
                             1, 0);
                    lex_mode = M_STR;
                end
            M_COMMENT:
                if (b == CH_LF || b == CH_NUL)
                    start_token(b);
            default: start_token(b);
        endcase
        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[i])
            exp_tokens.push_back(burst[i]);
    endtask

    task automatic compare_token();
        tok_exp_t e;
        if (exp_tokens.size() == 0)
        begin
            $error("unexpected token: kind %0d lit %h", tok_mon.token_kind,
                   tok_mon.literal_byte);
            fail_count++;
            return;
        end
        e = exp_tokens.pop_front();
        if (tok_mon.token_kind !== e.kind)
        begin
            $error("token_kind: expected %0d got %0d", e.kind, tok_mon.token_kind);
            fail_count++;
        end
        if (tok_mon.literal_byte !== e.lit)
        begin
            $error("literal_byte: expected %h got %h", e.lit, tok_mon.literal_byte);
            fail_count++;
        end
        if (tok_mon.byte_valid !== e.bvalid)
        begin
            $error("byte_valid: expected %b got %b", e.bvalid, tok_mon.byte_valid);
            fail_count++;
        end
        if (tok_mon.token_end !== e.tend)
        begin
            $error("token_end: expected %b got %b", e.tend, tok_mon.token_end);
            fail_count++;
        end
        if (tok_mon.line_number !== e.line)
        begin
            $error("line_number: expected %0d got %0d", e.line, tok_mon.line_number);
            fail_count++;
        end
        if (tok_mon.last_in_run !== e.last)
        begin
            $error("last_in_run: expected %b got %b", e.last, tok_mon.last_in_run);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        lex_mode = M_START;
        lookahead = 0;
        word_len = 0;
        cur_line = 1;
        foreach (kw_buf[i])
            kw_buf[i] = 0;
    end

    // Result checked before the new byte is lexed; a byte's results appear in the
    // cycle after it is accepted, at the earliest.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_mon.valid && tok_mon.ready)
                compare_token();
            if (char_mon.valid && char_mon.ready)
                lex_byte(char_mon.source_byte);
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the source tokenizer testbench: clock, reset, byte stimulus, result
// back-pressure and the verdict. Depends on stok_pkg, stok_if.sv, stok_checker.
`timescale 1ns / 1ps

module testbench;
    import stok_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    bit   long_hold;
    bit   recv_random;

    stok_char_if char_ch ();
    stok_tok_if  tok_ch ();

    source_tokenizer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_ch),
        .token_out (tok_ch)
    );

    stok_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_mon      (char_ch),
        .tok_mon       (tok_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: random stalls, a long hold when asked, none in quiet stretches.
    initial
    begin
        int n;
        tok_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
                tok_ch.ready <= 0;
            else if (!recv_random)
                tok_ch.ready <= 1;
            else
            begin
                n = $urandom_range(0, 12);
                if ($urandom_range(0, 1) == 0 || n == 0)
                    tok_ch.ready <= 1;
                else
                begin
                    tok_ch.ready <= 0;
                    repeat (n) @(negedge clk);
                    tok_ch.ready <= 1;
                end
            end
        end
    end

    bit gaps_on;

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            char_ch.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        char_ch.valid <= 1;
        char_ch.source_byte <= b;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_char();
        string alpha;
        alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        return alpha[$urandom_range(0, alpha.len() - 1)];
    endfunction

    task automatic send_fragment();
        string kw [20];
        string ops;
        int    n;
        kw = '{"fn", "let", "return", "if", "elif", "else", "while", "cont", "break",
               "copy", "true", "false", "bool", "array", "map", "str", "nil", "int",
               "float", "obj"};
        ops = "=!<>&|+-*/%(){}[],:.";
        case ($urandom_range(0, 9))
            0: send_text(kw[$urandom_range(0, 19)]);
            1:
            begin
                send_byte(8'("a" + $urandom_range(0, 25)));
                n = $urandom_range(0, 8);
                repeat (n) send_byte(pick_char());
            end
            2:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
                if ($urandom_range(0, 1))
                begin
                    send_byte(CH_DOT);
                    n = $urandom_range(0, 3);
                    repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
                end
            end
            3:
            begin
                send_byte(CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_byte(CH_BSL);
                        send_byte(8'($urandom_range(1, 255)));
                    end
                    else
                        send_byte(8'($urandom_range(1, 255)));
                end
                if ($urandom_range(0, 3) != 0)
                    send_byte(CH_QUOTE);
            end
            4:
            begin
                send_byte(ops[$urandom_range(0, ops.len() - 1)]);
                if ($urandom_range(0, 1))
                    send_byte(ops[$urandom_range(0, ops.len() - 1)]);
            end
            5: send_byte($urandom_range(0, 1) ? CH_LF : CH_SPACE);
            6: send_byte($urandom_range(0, 1) ? CH_CR : CH_TAB);
            7:
            begin
                send_byte(CH_HASH);
                n = $urandom_range(0, 4);
                repeat (n) send_byte(8'($urandom_range(1, 255)));
            end
            8: send_byte(8'($urandom_range(0, 255)));
            default: send_byte($urandom_range(0, 20) == 0 ? CH_NUL : CH_SPACE);
        endcase
    endtask

    initial
    begin
        long_hold = 0;
        recv_random = 0;
        gaps_on = 0;
        rst_n = 0;
        char_ch.valid = 0;
        char_ch.source_byte = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: keywords, types, long ident, operators, numbers, strings,
        // comment, CRLF, lone CR, high bytes, EOF
        send_text("return elif x1234567 int\r\n==!=<=>=&&||&|=<>!");
        send_text("12.5 7.a 3; \"a\\n\\t\\\\\\\"\\q\" #c\n\r \x80\xff");
        send_text(". \"x\\");
        send_byte(CH_NUL);
        send_byte(CH_NUL);

        gaps_on = 1;
        recv_random = 1;
        for (int i = 0; i < 20; i++)
            send_fragment();

        // sender pauses until the block has drained
        char_ch.valid <= 0;
        while (pending_count != 0)
            @(negedge clk);

        // long receiver hold while the sender keeps pushing
        long_hold = 1;
        fork
            begin
                repeat (60) @(negedge clk);
                long_hold = 0;
            end
            begin
                gaps_on = 0;
                send_text("while copy_x \"q\"\r\n");
                gaps_on = 1;
            end
        join

        recv_random = $urandom_range(0, 1);
        for (int i = 0; i < 8; i++)
            send_fragment();
        recv_random = 1;
        for (int i = 0; i < 12; i++)
            send_fragment();
        send_byte(CH_NUL);
        char_ch.valid <= 0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
